// ===== rtl/core/swm_pkg.sv =====
package swm_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 32;

    // Fixed field widths
    localparam int WSIZE_W     = 7;
    localparam int IN_TDATA_W  = 32;
    localparam int MEDIAN_W    = 33;
    localparam int OUT_TDATA_W = 40;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd3;

    // Per-cell status seen by the neighbors
    typedef struct packed {
        logic valid;  // cell holds a sample of the window
        logic gt;     // value above the incoming sample, or cell empty
        logic lt;     // value below the outgoing sample
    } swm_flags_t;

    // Broadcast control for the whole row
    typedef struct packed {
        logic upd;    // apply one insert/replace step this cycle
        logic grow;   // window not full: insert only, row grows by one
        logic low;    // full and new sample below outgoing: shift toward top
        logic clear;  // drop all valid bits
    } swm_ctrl_t;

endpackage

// ===== rtl/core/swm_history.sv =====
module swm_history #(
    parameter int DEPTH = swm_pkg::DEF_MAX_WINDOW,
    parameter int WIDTH = swm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/swm_cell.sv =====
module swm_cell #(
    parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  swm_pkg::swm_ctrl_t            ctrl,
    input  logic signed [SAMPLE_BITS-1:0] s_val,
    input  logic signed [SAMPLE_BITS-1:0] v_val,
    input  logic signed [SAMPLE_BITS-1:0] l_val,
    input  swm_pkg::swm_flags_t           l_flags,
    input  logic signed [SAMPLE_BITS-1:0] r_val,
    input  swm_pkg::swm_flags_t           r_flags,
    output logic signed [SAMPLE_BITS-1:0] val,
    output swm_pkg::swm_flags_t           flags
);
    import swm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic                          valid_reg, valid_next;
    logic                          gt, lt;

    assign gt = !valid_reg || (val_reg > s_val);
    assign lt = valid_reg && (val_reg < v_val);

    always_comb begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.upd) begin
            if (ctrl.grow || ctrl.low) begin
                // at or below the removed slot: shift up from the left neighbor
                if (ctrl.grow || l_flags.lt) begin
                    if (l_flags.gt) begin
                        val_next = l_val;
                        if (ctrl.grow) begin
                            valid_next = l_flags.valid;
                        end
                    end else if (gt) begin
                        val_next = s_val;
                        if (ctrl.grow) begin
                            valid_next = 1'b1;
                        end
                    end
                end
            end else if (!lt) begin
                // at or above the removed slot: pull down from the right neighbor
                if (!r_flags.gt) begin
                    val_next = r_val;
                end else if (!gt) begin
                    val_next = s_val;
                end
            end
        end
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        val_reg <= val_next;
    end

    assign val         = val_reg;
    assign flags.valid = valid_reg;
    assign flags.gt    = gt;
    assign flags.lt    = lt;

endmodule

// ===== rtl/core/sliding_window_median.sv =====
// Running median filter. Each transaction on the s_ side carries one signed
// sample; the block keeps the last K samples (K = window_size, 0 read as 1,
// values above MAX_WINDOW read as MAX_WINDOW) in arrival order in a history
// memory and in ascending order in a row of MAX_WINDOW sorting cells. Once
// K samples of a sequence are held, every sample gives one m_ transaction
// carrying twice the median (sum of the two middle values for an even K,
// twice the middle value for an odd K), so the half bit is exact. Samples
// before the window fills give no result. A sample with s_tlast set ends
// the sequence: its result (if any) has m_tlast set, and the window is
// emptied afterwards. Writing window_size through cfg_we/cfg_wdata also
// empties the window; write it only while the block is idle. The block
// takes one sample at a time: it accepts the sample while the history
// memory delivers the outgoing sample, then every cell of the row takes
// its insert/replace step at once, then it selects the middle cells and
// loads the output register, holding there while an earlier result still
// waits. The output register lets the next sample be accepted while a
// result still waits. No clearing pass is needed after reset.
module sliding_window_median #(
    parameter int MAX_WINDOW  = swm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: window_size
    input  logic                               cfg_we,
    input  logic [swm_pkg::WSIZE_W-1:0]        cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swm_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] sample
    input  logic                               s_tlast,   // last_sample
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swm_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [32:0] median_doubled, rest 0
    output logic                               m_tlast    // end_of_sequence
);
    import swm_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int KW = $clog2(MAX_WINDOW + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MED
    } state_t;

    // Clamp a register value to the supported window range
    function automatic logic [KW-1:0] eff_window(input logic [WSIZE_W-1:0] w);
        if (w == '0) begin
            return KW'(1);
        end
        if (int'(w) > MAX_WINDOW) begin
            return KW'(MAX_WINDOW);
        end
        return KW'(w);
    endfunction

    state_t                        state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] s_val_reg, s_val_next;
    logic                          last_reg, last_next;
    logic [KW-1:0]                 fill_reg, fill_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [KW-1:0]                 k_reg, k_next;
    logic                          produced_reg, produced_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [MEDIAN_W-1:0]           m_data_reg, m_data_next;
    logic                          m_tlast_reg, m_tlast_next;

    logic                          full;
    logic                          hist_we;
    logic [AW-1:0]                 hist_waddr;
    logic [SAMPLE_BITS-1:0]        hist_rdata;
    logic signed [SAMPLE_BITS-1:0] v_val;
    swm_ctrl_t                     ctrl;

    logic signed [SAMPLE_BITS-1:0] cell_val   [MAX_WINDOW];
    swm_flags_t                    cell_flags [MAX_WINDOW];

    logic [AW-1:0]                 idx_hi, idx_lo;
    logic signed [SAMPLE_BITS-1:0] med_hi, med_lo;
    logic [MEDIAN_W-1:0]           med_sum;

    assign full  = (fill_reg == k_reg);
    assign v_val = $signed(hist_rdata);

    // Outgoing sample sits at ptr_reg; it is read during the accept cycle
    assign hist_we    = (state_reg == ST_EXEC);
    assign hist_waddr = full ? ptr_reg : fill_reg[AW-1:0];

    swm_history #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (hist_we),
        .wr_addr (hist_waddr),
        .wr_data (s_val_reg),
        .rd_addr (ptr_reg),
        .rd_data (hist_rdata)
    );

    // Row control: one step per sample, clear on end of sequence or config write
    always_comb begin
        ctrl.upd   = (state_reg == ST_EXEC);
        ctrl.grow  = !full;
        ctrl.low   = (s_val_reg < v_val);
        ctrl.clear = cfg_we || ((state_reg == ST_EXEC) && last_reg);
    end

    // Sorting row; the ends see an empty cell on the right and
    // an always-below cell on the left
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] l_val, r_val;
        swm_flags_t                    l_flags, r_flags;

        if (i == 0) begin : g_first
            assign l_val   = '0;
            assign l_flags = '{valid: 1'b1, gt: 1'b0, lt: 1'b1};
        end else begin : g_mid_l
            assign l_val   = cell_val[i-1];
            assign l_flags = cell_flags[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_last
            assign r_val   = '0;
            assign r_flags = '{valid: 1'b0, gt: 1'b1, lt: 1'b0};
        end else begin : g_mid_r
            assign r_val   = cell_val[i+1];
            assign r_flags = cell_flags[i+1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .s_val   (s_val_reg),
            .v_val   (v_val),
            .l_val   (l_val),
            .l_flags (l_flags),
            .r_val   (r_val),
            .r_flags (r_flags),
            .val     (cell_val[i]),
            .flags   (cell_flags[i])
        );
    end

    // Middle cells: the same one twice for an odd window
    assign idx_hi  = AW'(k_reg >> 1);
    assign idx_lo  = k_reg[0] ? idx_hi : idx_hi - 1'b1;
    assign med_hi  = cell_val[idx_hi];
    assign med_lo  = cell_val[idx_lo];
    assign med_sum = MEDIAN_W'(med_hi) + MEDIAN_W'(med_lo);

    always_comb begin
        state_next    = state_reg;
        s_val_next    = s_val_reg;
        last_next     = last_reg;
        fill_next     = fill_reg;
        ptr_next      = ptr_reg;
        k_next        = k_reg;
        produced_next = produced_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        m_tlast_next  = m_tlast_reg;

        // drop the result once the transaction completes
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    s_val_next = $signed(s_tdata[SAMPLE_BITS-1:0]);
                    last_next  = s_tlast;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // a result once the window is full after this sample
                produced_next = full || ((fill_reg + 1'b1) == k_reg);
                if (full) begin
                    ptr_next = ((KW'(ptr_reg) + 1'b1) == k_reg) ? '0 : ptr_reg + 1'b1;
                end else begin
                    fill_next = fill_reg + 1'b1;
                    ptr_next  = '0;
                end
                if (last_reg) begin
                    fill_next = '0;
                    ptr_next  = '0;
                end
                state_next = ST_MED;
            end
            ST_MED: begin
                // hold while an earlier result still waits
                if (!m_tvalid_reg || m_tready) begin
                    if (produced_reg) begin
                        m_tvalid_next = 1'b1;
                        m_data_next   = med_sum;
                        m_tlast_next  = last_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we) begin
            k_next    = eff_window(cfg_wdata);
            fill_next = '0;
            ptr_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            ptr_reg      <= '0;
            k_reg        <= eff_window(WSIZE_RESET);
            produced_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            ptr_reg      <= ptr_next;
            k_reg        <= k_next;
            produced_reg <= produced_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        s_val_reg   <= s_val_next;
        last_reg    <= last_next;
        m_data_reg  <= m_data_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - MEDIAN_W){1'b0}}, m_data_reg};
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/core/swm_checker.sv =====
module swm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [swm_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import swm_pkg::*;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // One sample at a time: no transaction right after an accepted one
    a_in_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample is in work");

    // A fresh result traces back to an accepted sample, through the exec and median states
    a_out_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
        else $error("result without a matching input transaction");

    // No median field bits above the 33-bit result
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:MEDIAN_W] == '0))
        else $error("padding bits of result set");

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

// ===== tb/sv/sliding_window_median_tb.sv =====
`timescale 1ns / 100ps

module sliding_window_median_tb;

    localparam int WIN_MAX      = swm_pkg::DEF_MAX_WINDOW;
    localparam int DRAIN_CYCLES = 8;     // a few pipeline depths past the last result
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int RANDOM_ITEMS = 700;

    typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;
    // CHK_MODEL: ask the predictor; CHK_NONE: no result; CHK_TYPED: result given in the row
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_check_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [31:0] value;   // sample, or window_size for ROW_WINDOW
        logic        last;
        row_check_t  chk;
        logic [32:0] med;
        logic        eos;
    } stim_row_t;

    typedef struct {
        logic [32:0] median;
        logic        eos;
    } median_result_t;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [swm_pkg::WSIZE_W-1:0]        cfg_wdata = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [swm_pkg::IN_TDATA_W-1:0]     s_tdata   = '0;   // [31:0] sample
    logic                               s_tlast   = 1'b0; // last_sample
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [swm_pkg::OUT_TDATA_W-1:0]    m_tdata;          // [32:0] median_doubled, rest 0
    logic                               m_tlast;          // end_of_sequence

    sliding_window_median dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Median predictor: ring of samples in arrival order plus the same
    // samples kept in ascending order.
    // ---------------------------------------------------------------
    logic signed [31:0]          ring_hist [WIN_MAX];
    logic signed [31:0]          ordered   [WIN_MAX];
    int unsigned                 held      = 0;
    int unsigned                 ring_head = 0;
    logic [swm_pkg::WSIZE_W-1:0] win_reg   = swm_pkg::WSIZE_RESET;

    median_result_t median_q[$];

    int samples_sent    = 0;
    int windows_set     = 0;
    int results_checked = 0;
    int mismatch_count  = 0;

    // receiver control
    logic quiet       = 1'b0;
    int   hold_seq    = 0;
    int   hold_seen   = 0;
    int   hold_left   = 0;
    int   stall_left  = 0;

    // Zero reads as one, anything above the row length saturates.
    function automatic int unsigned window_len();
        if (win_reg == 0) return 1;
        if (win_reg > WIN_MAX) return WIN_MAX;
        return win_reg;
    endfunction

    // Drop the first matching value and close the gap.
    function automatic void drop_value(input logic signed [31:0] v);
        int unsigned i;
        bit          found;
        found = 1'b0;
        for (i = 0; i < held; i++) begin
            if (!found && ordered[i] == v) found = 1'b1;
            if (found && i + 1 < held) ordered[i] = ordered[i + 1];
        end
        if (found) held--;
    endfunction

    function automatic void add_value(input logic signed [31:0] v);
        int unsigned i;
        i = held;
        while (i > 0 && ordered[i - 1] > v) begin
            ordered[i] = ordered[i - 1];
            i--;
        end
        ordered[i] = v;
        held++;
    endfunction

    // Append one expected result at the tail of the queue.
    function automatic void queue_median(input median_result_t r);
        median_q.insert(median_q.size(), r);
    endfunction

    function automatic bit median_step(input logic signed [31:0] s, input bit last,
                                       output logic [32:0] twice);
        int unsigned        k;
        int unsigned        p;
        logic signed [32:0] a;
        logic signed [32:0] b;
        bit                 got;
        k     = window_len();
        twice = '0;
        got   = 1'b0;
        if (held > k) begin
            held      = 0;
            ring_head = 0;
        end
        if (held == k) begin
            // full: the oldest sample leaves, the new one takes its slot
            p = ring_head % k;
            drop_value(ring_hist[p]);
            ring_hist[p] = s;
            ring_head    = (p + 1) % k;
        end else begin
            ring_hist[held] = s;
            ring_head       = 0;
        end
        add_value(s);
        if (held == k) begin
            if (k % 2 != 0) begin
                a = ordered[k / 2];
                b = a;
            end else begin
                a = ordered[k / 2 - 1];
                b = ordered[k / 2];
            end
            twice = a + b;
            got   = 1'b1;
        end
        if (last) begin
            held      = 0;
            ring_head = 0;
        end
        return got;
    endfunction

    // Extremes, a narrow band full of duplicates, and plain random words.
    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    // Offer one sample, hold it until accepted, then record what it should yield.
    task automatic offer_sample(input logic [31:0] v, input bit last, input row_check_t chk,
                                input logic [32:0] med, input bit eos);
        median_result_t r;
        logic [32:0]    pm;
        bit             got;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
        got = median_step(v, last, pm);
        if (chk == CHK_TYPED) begin
            r.median = med;
            r.eos    = eos;
            queue_median(r);
        end else if (chk == CHK_MODEL && got) begin
            r.median = pm;
            r.eos    = last;
            queue_median(r);
        end
    endtask

    // Stop offering, wait for every pending result, then let the pipe empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (median_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [swm_pkg::WSIZE_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        win_reg   = v;
        held      = 0;
        ring_head = 0;
        windows_set++;
    endtask

    // ---------------------------------------------------------------
    // Directed stimulus: reset window first, then the size corner cases
    // ---------------------------------------------------------------
    localparam int DIR_ROWS = 26;
    stim_row_t dir_rows [DIR_ROWS] = '{
        // reset window of three, full-scale samples
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, CHK_NONE,  33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, CHK_NONE,  33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, CHK_TYPED, 33'h0_FFFF_FFFE, 1'b0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, CHK_TYPED, 33'h0_FFFF_FFFE, 1'b0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b1, CHK_TYPED, 33'h1_0000_0000, 1'b1},
        // sequence shorter than the window
        '{ROW_SAMPLE, 32'h0000_0005, 1'b1, CHK_NONE,  33'h0_0000_0000, 1'b0},
        // window size zero acts as one
        '{ROW_WINDOW, 32'd0,         1'b0, CHK_NONE,  33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, CHK_TYPED, 33'h1_FFFF_FFFE, 1'b0},
        '{ROW_SAMPLE, 32'h0000_0007, 1'b1, CHK_TYPED, 33'h0_0000_000E, 1'b1},
        // even window: sum of the two middles
        '{ROW_WINDOW, 32'd2,         1'b0, CHK_NONE,  33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, CHK_NONE,  33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, CHK_TYPED, 33'h1_FFFF_FFFF, 1'b0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, CHK_TYPED, 33'h1_FFFF_FFFF, 1'b1},
        // oversize window saturates; a short sequence gives nothing
        '{ROW_WINDOW, 32'd127,       1'b0, CHK_NONE,  33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h0000_002A, 1'b0, CHK_NONE,  33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'hFFFF_FFD6, 1'b1, CHK_NONE,  33'h0_0000_0000, 1'b0},
        // window of four with a duplicate leaving the window
        '{ROW_WINDOW, 32'd4,         1'b0, CHK_NONE,  33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h0000_000A, 1'b0, CHK_MODEL, 33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'hFFFF_FFFD, 1'b0, CHK_MODEL, 33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h0000_000A, 1'b0, CHK_MODEL, 33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h0000_0001, 1'b0, CHK_MODEL, 33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h0000_000A, 1'b0, CHK_MODEL, 33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h0000_0064, 1'b1, CHK_MODEL, 33'h0_0000_0000, 1'b0},
        // partial window, then a write that empties it
        '{ROW_SAMPLE, 32'h0000_0001, 1'b0, CHK_MODEL, 33'h0_0000_0000, 1'b0},
        '{ROW_WINDOW, 32'd1,         1'b0, CHK_NONE,  33'h0_0000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h0000_0000, 1'b1, CHK_TYPED, 33'h0_0000_0000, 1'b1}
    };

    // Window sizes of the first random phases; later phases draw their own.
    localparam int FIXED_PHASES = 8;
    localparam logic [6:0] PHASE_WINDOWS [FIXED_PHASES] = '{
        7'd64, 7'd127, 7'd5, 7'd2, 7'd1, 7'd0, 7'd3, 7'd16
    };

    initial begin
        int          base;
        int          phase;
        int          nseq;
        int          len;
        int unsigned k;
        logic [6:0]  w;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WINDOW)
                write_window(dir_rows[i].value[swm_pkg::WSIZE_W-1:0]);
            else
                offer_sample(dir_rows[i].value, dir_rows[i].last, dir_rows[i].chk,
                             dir_rows[i].med, dir_rows[i].eos);
        end

        base  = samples_sent;
        phase = 0;
        while (samples_sent - base < RANDOM_ITEMS) begin
            if (phase < FIXED_PHASES) begin
                w = PHASE_WINDOWS[phase];
            end else begin
                case ($urandom_range(0, 9))
                    0:       w = 7'($urandom_range(25, 64));
                    1:       w = 7'($urandom_range(65, 127));
                    2, 3:    w = 7'($urandom_range(9, 24));
                    default: w = 7'($urandom_range(1, 8));
                endcase
            end
            // run the tail of the stimulus without any idling
            if (samples_sent - base >= RANDOM_ITEMS - 100) quiet <= 1'b1;
            write_window(w);
            k    = window_len();
            nseq = (k > 24) ? 1 : $urandom_range(2, 5);
            for (int sq = 0; sq < nseq; sq++) begin
                // long receiver hold-off while samples keep coming
                if (phase == 2 && sq == 0) hold_seq <= hold_seq + 1;
                if (k > 1 && $urandom_range(0, 4) == 0)
                    len = $urandom_range(1, k - 1);
                else
                    len = k + $urandom_range(0, 24);
                for (int j = 0; j < len; j++) begin
                    offer_sample(pick_sample(), j == len - 1, CHK_MODEL, '0, 1'b0);
                    // pause mid-sequence until every result is back
                    if (phase == 3 && sq == 0 && j == len / 2) settle();
                end
            end
            phase++;
        end

        settle();
        $display("%0d samples sent over %0d window settings, %0d medians checked",
                 samples_sent, windows_set, results_checked);
        if (mismatch_count == 0 && median_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare every result transaction with the oldest pending median.
    always @(posedge aclk) begin
        median_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (median_q.size() == 0) begin
                $error("unexpected result: median_doubled %h end_of_sequence %b",
                       m_tdata[32:0], m_tlast);
                mismatch_count++;
            end else begin
                e = median_q.pop_front();
                results_checked++;
                if (m_tdata[32:0] !== e.median) begin
                    $error("median_doubled: expected %h, actual %h", e.median, m_tdata[32:0]);
                    mismatch_count++;
                end
                if (m_tlast !== e.eos) begin
                    $error("end_of_sequence: expected %b, actual %b", e.eos, m_tlast);
                    mismatch_count++;
                end
                if (m_tdata[swm_pkg::OUT_TDATA_W-1:swm_pkg::MEDIAN_W] !== '0) begin
                    $error("tdata padding: expected %h, actual %h", 7'h0,
                           m_tdata[swm_pkg::OUT_TDATA_W-1:swm_pkg::MEDIAN_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sliding_window_median.f =====
rtl/core/swm_pkg.sv
rtl/core/swm_history.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_median.sv
rtl/core/swm_checker.sv
tb/sv/sliding_window_median_tb.sv
